### rtl/mtfc_pkg.sv
// ----------------------------------------------------------------------------
// mtfc_pkg: shared types and constants of the move-to-front coder
// Symbol list size, derived widths, the per-cell command word and the
// result of the position/symbol search.
// ----------------------------------------------------------------------------
package mtfc_pkg;

   localparam int SYMBOL_COUNT = 256;
   localparam int SYM_W        = 8;
   localparam int POS_W        = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LAST_POS     = SYMBOL_COUNT - 1;
   localparam int GROUP_SIZE   = 16;
   localparam int GROUP_COUNT  = (SYMBOL_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_COUNT    = GROUP_COUNT * GROUP_SIZE;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // command broadcast to every cell of the list
   typedef struct packed {
      logic             load_identity;
      logic             compare;
      logic             shift;
      logic             decode;
      logic [SYM_W-1:0] key;
      logic [POS_W-1:0] pos;
      logic [SYM_W-1:0] front_sym;
   } cell_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
      logic [SYM_W-1:0] sym;
   } find_result_type;

endpackage

### rtl/mtfc_channels.sv
// ----------------------------------------------------------------------------
// mtfc channels: valid/ready interfaces of the move-to-front coder
// Request, response and control-register write channels.
// ----------------------------------------------------------------------------
interface mtfc_req_if;
   logic                      valid;
   logic                      ready;
   logic [mtfc_pkg::SYM_W-1:0] byte_in;
   logic                      block_start;

   modport source (output valid, output byte_in, output block_start, input ready);
   modport sink   (input valid, input byte_in, input block_start, output ready);
endinterface

interface mtfc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mtfc_pkg::SYM_W-1:0] byte_out;

   modport source (output valid, output byte_out, input ready);
   modport sink   (input valid, input byte_out, output ready);
endinterface

interface mtfc_csr_if;
   logic valid;
   logic ready;
   logic direction;

   modport source (output valid, output direction, input ready);
   modport sink   (input valid, input direction, output ready);
endinterface

### rtl/mtfc_cell.sv
// ----------------------------------------------------------------------------
// mtfc_cell: one entry of the symbol list
// Holds a symbol, compares it against the key (or its own place against the
// position) and takes its left neighbor's symbol on a shift that reaches it.
// ----------------------------------------------------------------------------
module mtfc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  mtfc_pkg::cell_ctrl_type    ctrl,
   input  logic [mtfc_pkg::POS_W-1:0] cell_index,
   input  logic [mtfc_pkg::SYM_W-1:0] prev_symbol,
   output logic [mtfc_pkg::SYM_W-1:0] symbol,
   output logic                       match
);
   import mtfc_pkg::*;

   logic [SYM_W-1:0] symbol_ff;
   logic             match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_ff <= SYM_W'(cell_index);
         match_ff  <= 1'b0;
      end else begin
         if (ctrl.load_identity) begin
            symbol_ff <= SYM_W'(cell_index);
         end else if (ctrl.shift && (cell_index <= ctrl.pos)) begin
            symbol_ff <= prev_symbol;
         end
         if (ctrl.compare) begin
            match_ff <= ctrl.decode ? (cell_index == ctrl.pos) : (symbol_ff == ctrl.key);
         end
      end
   end

   assign symbol = symbol_ff;
   assign match  = match_ff;

endmodule

### rtl/mtfc_finder.sv
// ----------------------------------------------------------------------------
// mtfc_finder: two-level registered reduction over the cell match flags
// Yields whether a cell matched, its position and the symbol it holds.
// ----------------------------------------------------------------------------
module mtfc_finder (
   input  logic                        clock,
   input  logic [mtfc_pkg::SYMBOL_COUNT-1:0] match_vec,
   input  logic [mtfc_pkg::SYM_W-1:0]  cell_symbol [mtfc_pkg::SYMBOL_COUNT],
   output mtfc_pkg::find_result_type   result
);
   import mtfc_pkg::*;

   logic [PAD_COUNT-1:0] match_pad;
   logic [SYM_W-1:0]     sym_pad [PAD_COUNT];

   logic             grp_found_ff [GROUP_COUNT];
   logic [POS_W-1:0] grp_pos_ff   [GROUP_COUNT];
   logic [SYM_W-1:0] grp_sym_ff   [GROUP_COUNT];
   logic             grp_found_in [GROUP_COUNT];
   logic [POS_W-1:0] grp_pos_in   [GROUP_COUNT];
   logic [SYM_W-1:0] grp_sym_in   [GROUP_COUNT];

   find_result_type result_ff;
   find_result_type result_in;

   assign match_pad = PAD_COUNT'(match_vec);

   for (genvar j = 0; j < PAD_COUNT; j++) begin : g_pad
      if (j < SYMBOL_COUNT) begin : g_real
         assign sym_pad[j] = cell_symbol[j];
      end else begin : g_fill
         assign sym_pad[j] = '0;
      end
   end

   // first level: OR of the gated entries within each group of cells
   for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_grp
      always_comb begin
         grp_found_in[g] = 1'b0;
         grp_pos_in[g]   = '0;
         grp_sym_in[g]   = '0;
         for (int i = 0; i < GROUP_SIZE; i++) begin
            if (match_pad[g * GROUP_SIZE + i]) begin
               grp_found_in[g] = 1'b1;
               grp_pos_in[g]   = grp_pos_in[g] | POS_W'(g * GROUP_SIZE + i);
               grp_sym_in[g]   = grp_sym_in[g] | sym_pad[g * GROUP_SIZE + i];
            end
         end
      end
   end

   // second level: OR across the groups
   always_comb begin
      result_in = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         result_in.found = result_in.found | grp_found_ff[g];
         result_in.pos   = result_in.pos   | grp_pos_ff[g];
         result_in.sym   = result_in.sym   | grp_sym_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_found_ff[g] <= grp_found_in[g];
         grp_pos_ff[g]   <= grp_pos_in[g];
         grp_sym_ff[g]   <= grp_sym_in[g];
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### rtl/move_to_front_coder.sv
// ----------------------------------------------------------------------------
// move_to_front_coder: move-to-front transform over a 256-symbol list
// Each request runs through these steps from acceptance until its response is
// registered: one to compare the key (or position) across the row of list
// cells, two for the registered 16-wide group reduction that finds the hit
// position and symbol, and one to shift the row while the response register
// loads. block_start reloads identity order at the accept edge itself, before
// the compare. The next request is taken in the cycle after the response is
// registered, so no new request is accepted while one is in flight; the shift
// step waits for as long as an earlier response still sits unread in the
// response register. Encode mode maps a symbol to its list position, decode
// maps a position to its symbol; either moves the symbol to the front.
// direction must be written only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module move_to_front_coder (
   input  logic            clock,
   input  logic            reset,
   mtfc_req_if.sink        req_if,
   mtfc_rsp_if.source      rsp_if,
   mtfc_csr_if.sink        csr_if
);
   import mtfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_GROUP,
      ST_TOP,
      ST_SHIFT
   } state_type;

   state_type        state_ff, state_in;
   logic             direction_ff, direction_in;
   logic [SYM_W-1:0] key_ff, key_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] byte_out_ff, byte_out_in;

   logic                    req_accept;
   logic                    slot_free;
   cell_ctrl_type           ctrl;
   find_result_type         result;
   logic [SYMBOL_COUNT-1:0] match_vec;
   logic [SYM_W-1:0]        cell_symbol [SYMBOL_COUNT];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      ctrl.load_identity = req_accept && req_if.block_start;
      ctrl.compare       = (state_ff == ST_COMPARE);
      ctrl.shift         = (state_ff == ST_SHIFT) && slot_free && result.found;
      ctrl.decode        = (direction_ff == DIR_DECODE);
      ctrl.key           = key_ff;
      ctrl.pos           = (state_ff == ST_COMPARE) ? pos_ff : result.pos;
      ctrl.front_sym     = result.sym;
   end

   for (genvar k = 0; k < SYMBOL_COUNT; k++) begin : g_cell
      logic [SYM_W-1:0] prev_symbol;
      if (k == 0) begin : g_head
         assign prev_symbol = ctrl.front_sym;
      end else begin : g_body
         assign prev_symbol = cell_symbol[k-1];
      end
      mtfc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cell_index  (POS_W'(k)),
         .prev_symbol (prev_symbol),
         .symbol      (cell_symbol[k]),
         .match       (match_vec[k])
      );
   end

   mtfc_finder u_finder (
      .clock       (clock),
      .match_vec   (match_vec),
      .cell_symbol (cell_symbol),
      .result      (result)
   );

   always_comb begin
      state_in     = state_ff;
      direction_in = direction_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      byte_out_in  = byte_out_ff;

      if (csr_if.valid && csr_if.ready) begin
         direction_in = csr_if.direction;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in = req_if.byte_in;
               // decode positions past the list saturate to the last entry
               if ({1'b0, req_if.byte_in} > (SYM_W + 1)'(LAST_POS)) begin
                  pos_in = POS_W'(LAST_POS);
               end else begin
                  pos_in = POS_W'(req_if.byte_in);
               end
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: state_in = ST_GROUP;
         ST_GROUP:   state_in = ST_TOP;
         ST_TOP:     state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (direction_ff == DIR_DECODE) begin
                  byte_out_in = result.sym;
               end else if (result.found) begin
                  byte_out_in = SYM_W'(result.pos);
               end else begin
                  // symbol not in the list passes through
                  byte_out_in = key_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         direction_ff <= DIR_ENCODE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         direction_ff <= direction_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      byte_out_ff <= byte_out_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.byte_out = byte_out_ff;

   // a new response is only ever loaded at the end of the shift step
   a_rsp_from_shift: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_if.ready) && rsp_valid_in |-> state_ff == ST_SHIFT)
      else $error("response loaded outside the shift step");

   // the list is a permutation, so at most one cell can hit
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GROUP |-> $onehot0(match_vec))
      else $error("more than one list cell matched");

   // decode positions are saturated into the list and always hit
   a_decode_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT && direction_ff == DIR_DECODE |-> result.found)
      else $error("decode position did not hit a list cell");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_COMPARE)
      else $error("accepted request did not start a compare");

endmodule
